[hdl/ptd_pkg.sv]
// Shared constants and types of the point to triangle squared distance unit.
// No dependencies; ptd_if, ptd_div, the top and the bench use its names.
package ptd_pkg;

  localparam int unsigned COORD_BITS = 20;
  localparam int unsigned FRAC_Q     = 16;
  localparam int unsigned PARAM_W    = FRAC_Q + 1;
  localparam int unsigned DIST_W     = 42;
  localparam int unsigned MUL_LAT    = 2;
  localparam int unsigned DIV_LAT    = FRAC_Q + 2;

  localparam logic [PARAM_W-1:0] PARAM_ONE = PARAM_W'(1) << FRAC_Q;

  typedef enum logic [2:0] {
    LINK_NONE   = 3'b001,
    LINK_T_OF_S = 3'b010,
    LINK_S_OF_T = 3'b100
  } link_e;

endpackage

[hdl/ptd_if.sv]
// Valid/ready channel interfaces of the point to triangle distance unit.
// Depends on ptd_pkg for the default coordinate width and output widths.
interface ptd_in_if #(
  parameter int unsigned COORD_BITS = ptd_pkg::COORD_BITS
) ();
  logic valid;
  logic ready;
  logic signed [COORD_BITS-1:0] v0_x, v0_y, v0_z;
  logic signed [COORD_BITS-1:0] v1_x, v1_y, v1_z;
  logic signed [COORD_BITS-1:0] v2_x, v2_y, v2_z;
  logic signed [COORD_BITS-1:0] point_x, point_y, point_z;

  modport source (
    output valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    output point_x, point_y, point_z,
    input  ready
  );
  modport sink (
    input  valid, v0_x, v0_y, v0_z, v1_x, v1_y, v1_z, v2_x, v2_y, v2_z,
    input  point_x, point_y, point_z,
    output ready
  );
endinterface

interface ptd_out_if ();
  logic valid;
  logic ready;
  logic [ptd_pkg::DIST_W-1:0]  dist_squared;
  logic [ptd_pkg::PARAM_W-1:0] param_s;
  logic [ptd_pkg::PARAM_W-1:0] param_t;
  logic                        degenerate;

  modport source (output valid, dist_squared, param_s, param_t, degenerate, input ready);
  modport sink (input valid, dist_squared, param_s, param_t, degenerate, output ready);
endinterface

[hdl/ptd_dly.sv]
// Enabled shift register that carries side data alongside a pipeline.
// No dependencies.
module ptd_dly #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 1
) (
  input  logic         clk_i,
  input  logic         en_i,
  input  logic [W-1:0] d_i,
  output logic [W-1:0] q_o
);

  logic [W-1:0] sr_q [N];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sr_q[0] <= d_i;
      for (int unsigned i = 1; i < N; i++) begin
        sr_q[i] <= sr_q[i-1];
      end
    end
  end

  assign q_o = sr_q[N-1];

endmodule

[hdl/ptd_mul.sv]
// Two stage signed multiplier: half-width partial products, then sum and sign.
// Depends on nothing.
module ptd_mul #(
  parameter int unsigned WA = 21,
  parameter int unsigned WB = 21
) (
  input  logic                       clk_i,
  input  logic                       en_i,
  input  logic signed [WA-1:0]       a_i,
  input  logic signed [WB-1:0]       b_i,
  output logic signed [WA+WB-1:0]    p_o
);

  localparam int unsigned HA = (WA + 1) / 2;
  localparam int unsigned HB = (WB + 1) / 2;
  localparam int unsigned PW = WA + WB;

  logic [WA-1:0] ma;
  logic [WB-1:0] mb;
  logic [HA+HB-1:0]           pll_d, pll_q;
  logic [HA+WB-HB-1:0]        plh_d, plh_q;
  logic [WA-HA+HB-1:0]        phl_d, phl_q;
  logic [WA-HA+WB-HB-1:0]     phh_d, phh_q;
  logic                       neg_q;
  logic [PW-1:0]              sum;

  assign ma = a_i[WA-1] ? (~a_i + WA'(1)) : a_i;
  assign mb = b_i[WB-1] ? (~b_i + WB'(1)) : b_i;

  assign pll_d = {{HB{1'b0}}, ma[HA-1:0]} * {{HA{1'b0}}, mb[HB-1:0]};
  assign plh_d = {{(WB-HB){1'b0}}, ma[HA-1:0]} * {{HA{1'b0}}, mb[WB-1:HB]};
  assign phl_d = {{HB{1'b0}}, ma[WA-1:HA]} * {{(WA-HA){1'b0}}, mb[HB-1:0]};
  assign phh_d = {{(WB-HB){1'b0}}, ma[WA-1:HA]} * {{(WA-HA){1'b0}}, mb[WB-1:HB]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pll_q <= pll_d;
      plh_q <= plh_d;
      phl_q <= phl_d;
      phh_q <= phh_d;
      neg_q <= a_i[WA-1] ^ b_i[WB-1];
    end
  end

  assign sum = PW'(pll_q) + (PW'(plh_q) << HB) + (PW'(phl_q) << HA)
             + (PW'(phh_q) << (HA + HB));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_o <= neg_q ? -signed'(sum) : signed'(sum);
    end
  end

endmodule

[hdl/ptd_div.sv]
// Pipelined restoring divider: num/den to Q1.16, rounded half up, clamped 0..1.
// Depends on ptd_pkg; one quotient bit per stage.
module ptd_div #(
  parameter int unsigned W = 90
) (
  input  logic                              clk_i,
  input  logic                              en_i,
  input  logic signed [W-1:0]               num_i,
  input  logic signed [W-1:0]               den_i,
  output logic [ptd_pkg::PARAM_W-1:0]       q_o
);

  localparam int unsigned UW    = W - 1;
  localparam int unsigned STEPS = ptd_pkg::FRAC_Q;

  logic [UW-1:0]    r_q   [STEPS+1];
  logic [UW-1:0]    d_q   [STEPS+1];
  logic [STEPS-1:0] qb_q  [STEPS+1];
  logic             run_q [STEPS+1];
  logic             one_q [STEPS+1];
  logic             num_pos, den_pos, lt;
  logic [UW:0]      rf2;
  logic             rnd;

  assign num_pos = !num_i[W-1] && (|num_i);
  assign den_pos = !den_i[W-1] && (|den_i);
  assign lt      = num_i[UW-1:0] < den_i[UW-1:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      r_q[0]   <= num_i[UW-1:0];
      d_q[0]   <= den_i[UW-1:0];
      qb_q[0]  <= '0;
      run_q[0] <= num_pos && den_pos && lt;
      one_q[0] <= num_pos && den_pos && !lt;
    end
  end

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    logic [UW:0] r2;
    logic        ge;
    logic [UW:0] rn;
    assign r2 = {r_q[k], 1'b0};
    assign ge = r2 >= {1'b0, d_q[k]};
    assign rn = ge ? (r2 - {1'b0, d_q[k]}) : r2;
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        r_q[k+1]   <= rn[UW-1:0];
        d_q[k+1]   <= d_q[k];
        qb_q[k+1]  <= {qb_q[k][STEPS-2:0], ge};
        run_q[k+1] <= run_q[k];
        one_q[k+1] <= one_q[k];
      end
    end
  end

  assign rf2 = {r_q[STEPS], 1'b0};
  assign rnd = rf2 >= {1'b0, d_q[STEPS]};

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (one_q[STEPS]) begin
        q_o <= ptd_pkg::PARAM_ONE;
      end else if (run_q[STEPS]) begin
        q_o <= ptd_pkg::PARAM_W'(qb_q[STEPS]) + ptd_pkg::PARAM_W'(rnd);
      end else begin
        q_o <= '0;
      end
    end
  end

endmodule

[hdl/point_triangle_distance_sq_unit.sv]
// Top level of the point to triangle squared distance unit.
// Depends on ptd_pkg, ptd_if, ptd_dly, ptd_mul and ptd_div.
//
// Usage:
//   in_i carries one query per beat: three triangle vertices and a point,
//   each a signed fixed point coordinate of COORD_BITS bits. out_o returns
//   one beat per query: squared distance (unsigned, twice the input fraction
//   bits), the edge weights param_s and param_t in Q1.16, and a degenerate
//   flag for triangles with zero Gram determinant (distance to the first
//   vertex, both weights zero).
//   One beat enters per cycle while out_o holds no beat that is not taken.
//   The depth is set by the 16 quotient stages of the two parallel dividers,
//   the split multiplier stages and the single register stages between them.
//   The pipeline moves as one: when out_o holds a beat that is not taken,
//   every stage holds and in_i.ready drops, also where stages are empty.
//   Reset clears all valid bits; data registers are not reset.
module point_triangle_distance_sq_unit #(
  parameter int unsigned COORD_BITS = ptd_pkg::COORD_BITS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ptd_in_if.sink      in_i,
  ptd_out_if.source   out_o
);

  localparam int unsigned D    = COORD_BITS + 1;
  localparam int unsigned G    = 2 * D + 2;
  localparam int unsigned PW   = 2 * G;
  localparam int unsigned W    = 2 * G + 2;
  localparam int unsigned ML   = ptd_pkg::MUL_LAT;
  localparam int unsigned SW   = ptd_pkg::PARAM_W + 1;
  localparam int unsigned DQ   = D + SW + 1;
  localparam int unsigned RW   = DQ - ptd_pkg::FRAC_Q;
  localparam int unsigned SQW  = 2 * RW + 2;
  localparam int unsigned SUMW = SQW + 2;
  localparam int unsigned LAT  = 4 * ML + ptd_pkg::DIV_LAT + 7;
  localparam int unsigned A_DLY  = ML;
  localparam int unsigned E_DLY  = 2 * ML + ptd_pkg::DIV_LAT + 4;
  localparam int unsigned DF_DLY = E_DLY + ML;
  localparam int unsigned ST_DLY = 2 * ML + 1;
  localparam int unsigned AW   = 5 * G + G + 2;

  logic           en;
  logic [LAT-1:0] v_q;

  assign en        = !v_q[LAT-1] || out_o.ready;
  assign in_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[LAT-2:0], in_i.valid};
    end
  end

  // stage 1: edges and point offset
  logic signed [COORD_BITS-1:0] v0 [3], v1 [3], v2 [3], pt [3];
  logic signed [D-1:0] e0_q [3], e1_q [3], df_q [3];

  assign v0 = '{in_i.v0_x, in_i.v0_y, in_i.v0_z};
  assign v1 = '{in_i.v1_x, in_i.v1_y, in_i.v1_z};
  assign v2 = '{in_i.v2_x, in_i.v2_y, in_i.v2_z};
  assign pt = '{in_i.point_x, in_i.point_y, in_i.point_z};

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int unsigned k = 0; k < 3; k++) begin
        e0_q[k] <= D'(v1[k]) - D'(v0[k]);
        e1_q[k] <= D'(v2[k]) - D'(v0[k]);
        df_q[k] <= D'(pt[k]) - D'(v0[k]);
      end
    end
  end

  // stages 2-3: Gram products
  logic signed [2*D-1:0] p00 [3], p01 [3], p11 [3], pd0 [3], pd1 [3];

  for (genvar k = 0; k < 3; k++) begin : g_gram
    ptd_mul #(.WA(D), .WB(D)) u_m00 (
      .clk_i, .en_i(en), .a_i(e0_q[k]), .b_i(e0_q[k]), .p_o(p00[k]));
    ptd_mul #(.WA(D), .WB(D)) u_m01 (
      .clk_i, .en_i(en), .a_i(e0_q[k]), .b_i(e1_q[k]), .p_o(p01[k]));
    ptd_mul #(.WA(D), .WB(D)) u_m11 (
      .clk_i, .en_i(en), .a_i(e1_q[k]), .b_i(e1_q[k]), .p_o(p11[k]));
    ptd_mul #(.WA(D), .WB(D)) u_md0 (
      .clk_i, .en_i(en), .a_i(df_q[k]), .b_i(e0_q[k]), .p_o(pd0[k]));
    ptd_mul #(.WA(D), .WB(D)) u_md1 (
      .clk_i, .en_i(en), .a_i(df_q[k]), .b_i(e1_q[k]), .p_o(pd1[k]));
  end

  // stage 4: Gram sums
  logic signed [G-1:0]   a00_q, a01_q, a11_q, b0_q, b1_q;
  logic signed [G+1:0]   den_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      a00_q <= G'(p00[0]) + G'(p00[1]) + G'(p00[2]);
      a01_q <= G'(p01[0]) + G'(p01[1]) + G'(p01[2]);
      a11_q <= G'(p11[0]) + G'(p11[1]) + G'(p11[2]);
      b0_q  <= -(G'(pd0[0]) + G'(pd0[1]) + G'(pd0[2]));
      b1_q  <= -(G'(pd1[0]) + G'(pd1[1]) + G'(pd1[2]));
      den_q <= (G+2)'(G'(p00[0]) + G'(p00[1]) + G'(p00[2]))
             - ((G+2)'(G'(p01[0]) + G'(p01[1]) + G'(p01[2])) <<< 1)
             + (G+2)'(G'(p11[0]) + G'(p11[1]) + G'(p11[2]));
    end
  end

  // stages 5-6: determinant and region products
  logic signed [PW-1:0] m_a00a11, m_a01a01, m_a01b1, m_a11b0, m_a01b0, m_a00b1;

  ptd_mul #(.WA(G), .WB(G)) u_det0 (
    .clk_i, .en_i(en), .a_i(a00_q), .b_i(a11_q), .p_o(m_a00a11));
  ptd_mul #(.WA(G), .WB(G)) u_det1 (
    .clk_i, .en_i(en), .a_i(a01_q), .b_i(a01_q), .p_o(m_a01a01));
  ptd_mul #(.WA(G), .WB(G)) u_t00 (
    .clk_i, .en_i(en), .a_i(a01_q), .b_i(b1_q), .p_o(m_a01b1));
  ptd_mul #(.WA(G), .WB(G)) u_t01 (
    .clk_i, .en_i(en), .a_i(a11_q), .b_i(b0_q), .p_o(m_a11b0));
  ptd_mul #(.WA(G), .WB(G)) u_t10 (
    .clk_i, .en_i(en), .a_i(a01_q), .b_i(b0_q), .p_o(m_a01b0));
  ptd_mul #(.WA(G), .WB(G)) u_t11 (
    .clk_i, .en_i(en), .a_i(a00_q), .b_i(b1_q), .p_o(m_a00b1));

  logic [AW-1:0] a_vec, a_dly;

  assign a_vec = {a00_q, a01_q, a11_q, b0_q, b1_q, den_q};

  ptd_dly #(.W(AW), .N(A_DLY)) u_a_dly (.clk_i, .en_i(en), .d_i(a_vec), .q_o(a_dly));

  // stage 7: determinant and unnormalized parameters
  logic signed [W-1:0] det_q, t0_q, t1_q;
  logic                degen_q;
  logic signed [PW:0]  det_d;
  logic [AW-1:0]       a7_q;

  assign det_d = (PW+1)'(m_a00a11) - (PW+1)'(m_a01a01);

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q   <= W'(det_d);
      t0_q    <= W'((PW+1)'(m_a01b1) - (PW+1)'(m_a11b0));
      t1_q    <= W'((PW+1)'(m_a01b0) - (PW+1)'(m_a00b1));
      degen_q <= det_d == '0;
      a7_q    <= a_dly;
    end
  end

  // stage 8: region select
  logic signed [G-1:0]   c_a00, c_a01, c_a11, c_b0, c_b1;
  logic signed [G+1:0]   c_den;
  logic signed [W-1:0]   ns_d, ds_d, nt_d, dt_d, ns_q, ds_q, nt_q, dt_q;
  logic signed [W-1:0]   tsum;
  logic signed [G:0]     m0a, m1a, m0b, m1b;
  logic signed [G+1:0]   numer;
  ptd_pkg::link_e        link_d, link_q;
  logic                  degen8_q;

  assign c_a00 = signed'(a7_q[AW-1 -: G]);
  assign c_a01 = signed'(a7_q[AW-1-G -: G]);
  assign c_a11 = signed'(a7_q[AW-1-2*G -: G]);
  assign c_b0  = signed'(a7_q[AW-1-3*G -: G]);
  assign c_b1  = signed'(a7_q[AW-1-4*G -: G]);
  assign c_den = signed'(a7_q[G+1:0]);

  assign tsum  = t0_q + t1_q;
  assign m0a   = (G+1)'(c_a01) + (G+1)'(c_b0);
  assign m1a   = (G+1)'(c_a11) + (G+1)'(c_b1);
  assign m0b   = (G+1)'(c_a01) + (G+1)'(c_b1);
  assign m1b   = (G+1)'(c_a00) + (G+1)'(c_b0);
  assign numer = (G+2)'(c_a11) + (G+2)'(c_b1) - (G+2)'(c_a01) - (G+2)'(c_b0);

  always_comb begin
    ns_d   = '0;
    ds_d   = '0;
    nt_d   = '0;
    dt_d   = '0;
    link_d = ptd_pkg::LINK_NONE;
    if (!degen_q) begin
      if (det_q >= tsum) begin
        if (t0_q[W-1]) begin
          if (t1_q[W-1] && c_b0[G-1]) begin
            ns_d = -W'(c_b0);
            ds_d = W'(c_a00);
          end else begin
            nt_d = -W'(c_b1);
            dt_d = W'(c_a11);
          end
        end else if (t1_q[W-1]) begin
          ns_d = -W'(c_b0);
          ds_d = W'(c_a00);
        end else begin
          ns_d = t0_q;
          ds_d = det_q;
          nt_d = t1_q;
          dt_d = det_q;
        end
      end else if (t0_q[W-1]) begin
        if (m0a < m1a) begin
          ns_d   = W'(m1a) - W'(m0a);
          ds_d   = W'(c_den);
          link_d = ptd_pkg::LINK_T_OF_S;
        end else begin
          nt_d = -W'(c_b1);
          dt_d = W'(c_a11);
        end
      end else if (t1_q[W-1]) begin
        if (m0b < m1b) begin
          nt_d   = W'(m1b) - W'(m0b);
          dt_d   = W'(c_den);
          link_d = ptd_pkg::LINK_S_OF_T;
        end else begin
          ns_d = -W'(c_b0);
          ds_d = W'(c_a00);
        end
      end else if (numer[G+1] || numer == '0) begin
        nt_d = W'(1);
        dt_d = W'(1);
      end else begin
        ns_d   = W'(numer);
        ds_d   = W'(c_den);
        link_d = ptd_pkg::LINK_T_OF_S;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ns_q     <= ns_d;
      ds_q     <= ds_d;
      nt_q     <= nt_d;
      dt_q     <= dt_d;
      link_q   <= link_d;
      degen8_q <= degen_q;
    end
  end

  // stages 9-26: parameter quotients
  logic [ptd_pkg::PARAM_W-1:0] s_raw, t_raw;
  logic [3:0]                  lk_dly;

  ptd_div #(.W(W)) u_div_s (.clk_i, .en_i(en), .num_i(ns_q), .den_i(ds_q), .q_o(s_raw));
  ptd_div #(.W(W)) u_div_t (.clk_i, .en_i(en), .num_i(nt_q), .den_i(dt_q), .q_o(t_raw));

  ptd_dly #(.W(4), .N(ptd_pkg::DIV_LAT)) u_lk_dly (
    .clk_i, .en_i(en), .d_i({link_q, degen8_q}), .q_o(lk_dly));

  // stage 27: resolve the edge opposite the first vertex
  logic [ptd_pkg::PARAM_W-1:0] s_q, t_q;
  logic                        degen27_q;
  ptd_pkg::link_e              lk;

  assign lk = ptd_pkg::link_e'(lk_dly[3:1]);

  always_ff @(posedge clk_i) begin
    if (en) begin
      degen27_q <= lk_dly[0];
      case (lk)
        ptd_pkg::LINK_T_OF_S: begin
          s_q <= s_raw;
          t_q <= ptd_pkg::PARAM_ONE - s_raw;
        end
        ptd_pkg::LINK_S_OF_T: begin
          s_q <= ptd_pkg::PARAM_ONE - t_raw;
          t_q <= t_raw;
        end
        default: begin
          s_q <= s_raw;
          t_q <= t_raw;
        end
      endcase
    end
  end

  // stages 28-30: offset from the closest point
  logic [6*D-1:0] e_vec, e_dly;
  logic [3*D-1:0] df_vec, df_dly;

  assign e_vec  = {e0_q[0], e0_q[1], e0_q[2], e1_q[0], e1_q[1], e1_q[2]};
  assign df_vec = {df_q[0], df_q[1], df_q[2]};

  ptd_dly #(.W(6*D), .N(E_DLY)) u_e_dly (.clk_i, .en_i(en), .d_i(e_vec), .q_o(e_dly));
  ptd_dly #(.W(3*D), .N(DF_DLY)) u_df_dly (.clk_i, .en_i(en), .d_i(df_vec), .q_o(df_dly));

  logic signed [SW-1:0]   s_sg, t_sg;
  logic signed [D+SW-1:0] ps [3], pt2 [3];
  logic [RW-1:0]          r_q [3];
  logic signed [SQW-1:0]  sq [3];

  assign s_sg = signed'({1'b0, s_q});
  assign t_sg = signed'({1'b0, t_q});

  for (genvar k = 0; k < 3; k++) begin : g_off
    logic signed [D-1:0]  e0k, e1k, dfk;
    logic signed [DQ-1:0] dq;
    logic [DQ-1:0]        mag, rs;

    assign e0k = signed'(e_dly[6*D-1-k*D -: D]);
    assign e1k = signed'(e_dly[3*D-1-k*D -: D]);
    assign dfk = signed'(df_dly[3*D-1-k*D -: D]);

    ptd_mul #(.WA(D), .WB(SW)) u_ms (
      .clk_i, .en_i(en), .a_i(e0k), .b_i(s_sg), .p_o(ps[k]));
    ptd_mul #(.WA(D), .WB(SW)) u_mt (
      .clk_i, .en_i(en), .a_i(e1k), .b_i(t_sg), .p_o(pt2[k]));

    assign dq  = (DQ'(dfk) <<< ptd_pkg::FRAC_Q) - DQ'(ps[k]) - DQ'(pt2[k]);
    assign mag = dq[DQ-1] ? -dq : dq;
    assign rs  = mag + (DQ'(1) << (ptd_pkg::FRAC_Q - 1));

    always_ff @(posedge clk_i) begin
      if (en) begin
        r_q[k] <= rs[DQ-1:ptd_pkg::FRAC_Q];
      end
    end

    ptd_mul #(.WA(RW+1), .WB(RW+1)) u_sq (
      .clk_i, .en_i(en), .a_i(signed'({1'b0, r_q[k]})), .b_i(signed'({1'b0, r_q[k]})),
      .p_o(sq[k]));
  end

  // stage 33: sum, saturate, output
  logic [2*ptd_pkg::PARAM_W:0] st_dly;
  logic [SUMW-1:0]             dsum;
  logic [ptd_pkg::DIST_W-1:0]  dist_d, dist_q;
  logic [ptd_pkg::PARAM_W-1:0] so_q, to_q;
  logic                        dg_q;

  ptd_dly #(.W(2*ptd_pkg::PARAM_W+1), .N(ST_DLY)) u_st_dly (
    .clk_i, .en_i(en), .d_i({s_q, t_q, degen27_q}), .q_o(st_dly));

  assign dsum = SUMW'(unsigned'(sq[0])) + SUMW'(unsigned'(sq[1]))
              + SUMW'(unsigned'(sq[2]));

  if (SUMW > ptd_pkg::DIST_W) begin : g_sat
    assign dist_d = (|dsum[SUMW-1:ptd_pkg::DIST_W]) ? '1 : dsum[ptd_pkg::DIST_W-1:0];
  end else begin : g_nosat
    assign dist_d = ptd_pkg::DIST_W'(dsum);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dist_q <= dist_d;
      so_q   <= st_dly[2*ptd_pkg::PARAM_W -: ptd_pkg::PARAM_W];
      to_q   <= st_dly[ptd_pkg::PARAM_W:1];
      dg_q   <= st_dly[0];
    end
  end

  assign out_o.valid        = v_q[LAT-1];
  assign out_o.dist_squared = dist_q;
  assign out_o.param_s      = so_q;
  assign out_o.param_t      = to_q;
  assign out_o.degenerate   = dg_q;

  a_degen_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.degenerate |-> out_o.param_s == '0 && out_o.param_t == '0)
    else $error("degenerate beat with nonzero weights");

  a_param_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> out_o.param_s <= ptd_pkg::PARAM_ONE && out_o.param_t <= ptd_pkg::PARAM_ONE)
    else $error("edge weight above one");

  a_hold_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.ready |-> !in_i.ready)
    else $error("pipeline advanced under a held output");

endmodule

[tb/sv/point_triangle_distance_sq_unit_test.sv]
// Self-checking testbench of point_triangle_distance_sq_unit: directed and random queries,
// with an in-bench closest-point predictor and random stalls on both channels.
// Depends on ptd_pkg, ptd_if and the unit's RTL.
module point_triangle_distance_sq_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [ptd_pkg::COORD_BITS-1:0] coord_t;
  typedef logic signed [159:0] wide_t;

  typedef struct {
    coord_t c[12];
  } tri_query_t;

  typedef struct {
    logic [ptd_pkg::DIST_W-1:0]  dist_squared;
    logic [ptd_pkg::PARAM_W-1:0] param_s;
    logic [ptd_pkg::PARAM_W-1:0] param_t;
    logic                        degenerate;
  } closest_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  ptd_in_if  in_if ();
  ptd_out_if out_if ();

  point_triangle_distance_sq_unit u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  always #10 clk_i = ~clk_i;

  tri_query_t pending_q[$];
  closest_t   expected_q[$];
  tri_query_t cur_query;
  int         snd_idle = 15;
  int         rcv_idle = 71;
  int         err_cnt = 0;

  function automatic void add_query(tri_query_t q);
    pending_q.insert(pending_q.size(), q);
  endfunction

  function automatic longint unsigned weight_q16(wide_t num, wide_t den);
    if (den <= 0 || num <= 0) return 0;
    if (num >= den) return longint'(ptd_pkg::PARAM_ONE);
    return longint'(((num <<< 17) + den) / (den <<< 1));
  endfunction

  function automatic closest_t closest_point(tri_query_t q);
    closest_t res;
    longint v0[3], e0[3], e1[3], df[3];
    longint a00, a01, a11, b0, b1, denom, m0, m1, numer, s, t, dq, mag, r, dsq;
    wide_t det, t0, t1, wa00, wa01, wa11, wb0, wb1;
    a00 = 0; a01 = 0; a11 = 0; b0 = 0; b1 = 0; s = 0; t = 0; dsq = 0;
    for (int k = 0; k < 3; k++) begin
      v0[k] = q.c[k];
      e0[k] = longint'(q.c[3+k]) - v0[k];
      e1[k] = longint'(q.c[6+k]) - v0[k];
      df[k] = longint'(q.c[9+k]) - v0[k];
      a00 += e0[k] * e0[k];
      a01 += e0[k] * e1[k];
      a11 += e1[k] * e1[k];
      b0 -= df[k] * e0[k];
      b1 -= df[k] * e1[k];
    end
    wa00 = a00; wa01 = a01; wa11 = a11; wb0 = b0; wb1 = b1;
    det = wa00 * wa11 - wa01 * wa01;
    denom = a00 - 2 * a01 + a11;
    res.degenerate = (det == 0);
    if (!res.degenerate) begin
      t0 = wa01 * wb1 - wa11 * wb0;
      t1 = wa01 * wb0 - wa00 * wb1;
      if (det >= t0 + t1) begin
        if (t0 < 0) begin
          if (t1 < 0 && b0 < 0) s = weight_q16(-b0, a00);
          else t = weight_q16(-b1, a11);
        end else if (t1 < 0) begin
          s = weight_q16(-b0, a00);
        end else begin
          s = weight_q16(t0, det);
          t = weight_q16(t1, det);
        end
      end else if (t0 < 0) begin
        m0 = a01 + b0; m1 = a11 + b1;
        if (m0 < m1) begin
          s = weight_q16(m1 - m0, denom);
          t = longint'(ptd_pkg::PARAM_ONE) - s;
        end else begin
          t = weight_q16(-b1, a11);
        end
      end else if (t1 < 0) begin
        m0 = a01 + b1; m1 = a00 + b0;
        if (m0 < m1) begin
          t = weight_q16(m1 - m0, denom);
          s = longint'(ptd_pkg::PARAM_ONE) - t;
        end else begin
          s = weight_q16(-b0, a00);
        end
      end else begin
        numer = a11 + b1 - a01 - b0;
        if (numer <= 0) begin
          t = longint'(ptd_pkg::PARAM_ONE);
        end else begin
          s = weight_q16(numer, denom);
          t = longint'(ptd_pkg::PARAM_ONE) - s;
        end
      end
    end
    for (int k = 0; k < 3; k++) begin
      dq = df[k] * 65536 - e0[k] * s - e1[k] * t;
      mag = (dq < 0) ? -dq : dq;
      r = (mag + 32768) >>> 16;
      dsq += r * r;
    end
    if (dsq > (64'(1) << ptd_pkg::DIST_W) - 1) dsq = (64'(1) << ptd_pkg::DIST_W) - 1;
    res.dist_squared = dsq[ptd_pkg::DIST_W-1:0];
    res.param_s = s[ptd_pkg::PARAM_W-1:0];
    res.param_t = t[ptd_pkg::PARAM_W-1:0];
    return res;
  endfunction

  function automatic tri_query_t make_query(int v[12]);
    tri_query_t q;
    for (int k = 0; k < 12; k++) q.c[k] = coord_t'(v[k]);
    return q;
  endfunction

  function automatic tri_query_t random_query();
    tri_query_t q;
    int kind, span, base[3], d[3], mult;
    kind = $urandom_range(9);
    span = 1 << $urandom_range(19, 2);
    for (int k = 0; k < 3; k++) base[k] = $signed($urandom()) >>> 12;
    for (int k = 0; k < 12; k++) begin
      if (kind <= 1) q.c[k] = coord_t'($urandom());
      else q.c[k] = coord_t'(base[k % 3] + $signed($urandom_range(2 * span)) - span);
    end
    if (kind == 8) begin
      mult = $signed($urandom_range(6)) - 3;
      for (int k = 0; k < 3; k++) begin
        d[k] = $signed($urandom_range(2 * span)) - span;
        q.c[3+k] = coord_t'(q.c[k] + d[k]);
        q.c[6+k] = coord_t'(q.c[k] + mult * d[k]);
      end
    end else if (kind == 9) begin
      for (int k = 0; k < 3; k++) q.c[3+k] = q.c[k];
    end
    return q;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_if.valid <= 1'b0;
    end else begin
      if (in_if.valid && in_if.ready) begin
        expected_q.insert(expected_q.size(), closest_point(cur_query));
      end
      if (!in_if.valid || in_if.ready) begin
        if (pending_q.size() > 0 && $urandom_range(99) >= snd_idle) begin
          cur_query = pending_q.pop_front();
          in_if.v0_x <= cur_query.c[0];
          in_if.v0_y <= cur_query.c[1];
          in_if.v0_z <= cur_query.c[2];
          in_if.v1_x <= cur_query.c[3];
          in_if.v1_y <= cur_query.c[4];
          in_if.v1_z <= cur_query.c[5];
          in_if.v2_x <= cur_query.c[6];
          in_if.v2_y <= cur_query.c[7];
          in_if.v2_z <= cur_query.c[8];
          in_if.point_x <= cur_query.c[9];
          in_if.point_y <= cur_query.c[10];
          in_if.point_z <= cur_query.c[11];
          in_if.valid <= 1'b1;
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    closest_t exp_res;
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else begin
      if (out_if.valid && out_if.ready) begin
        if (expected_q.size() == 0) begin
          $error("result beat with nothing expected");
          err_cnt++;
        end else begin
          exp_res = expected_q.pop_front();
          if (out_if.dist_squared !== exp_res.dist_squared) begin
            $error("dist_squared expected %0d actual %0d", exp_res.dist_squared,
                   out_if.dist_squared);
            err_cnt++;
          end
          if (out_if.param_s !== exp_res.param_s) begin
            $error("param_s expected %0d actual %0d", exp_res.param_s, out_if.param_s);
            err_cnt++;
          end
          if (out_if.param_t !== exp_res.param_t) begin
            $error("param_t expected %0d actual %0d", exp_res.param_t, out_if.param_t);
            err_cnt++;
          end
          if (out_if.degenerate !== exp_res.degenerate) begin
            $error("degenerate expected %0d actual %0d", exp_res.degenerate,
                   out_if.degenerate);
            err_cnt++;
          end
        end
      end
      out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end
  end

  initial begin
    int mx, mn;
    mx = (1 << (ptd_pkg::COORD_BITS - 1)) - 1;
    mn = -(1 << (ptd_pkg::COORD_BITS - 1));
    in_if.valid = 1'b0;
    out_if.ready = 1'b0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    add_query(make_query('{0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0}));
    add_query(make_query('{mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx, mx}));
    add_query(make_query('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn, mn}));
    add_query(make_query('{mn, mn, mn, mn, mn, mn, mn, mn, mn, mx, mx, mx}));
    add_query(make_query('{mn, mn, mn, mx, mn, mn, mn, mx, mn, mx, mx, mx}));
    add_query(make_query('{mx, mn, mx, mn, mx, mn, mx, mx, mn, mn, mn, mx}));
    add_query(make_query('{mn, mn, mn, mx, mx, mx, 0, 0, 0, mn, mx, 0}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, 200, 200, 300}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, -100, -100, 0}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, 2000, -50, 0}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, -50, 2000, 0}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, 500, -300, 5}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, -300, 500, 5}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, 800, 800, 0}));
    add_query(make_query('{0, 0, 0, 1000, 0, 0, 0, 1000, 0, 3000, 3000, -7}));
    add_query(make_query('{5, 5, 5, 5, 5, 5, 5, 5, 5, -9, 4, 100}));
    add_query(make_query('{0, 0, 0, 10, 20, 30, 30, 60, 90, 7, -3, 2}));
    add_query(make_query('{0, 0, 0, 10, 20, 30, 10, 20, 30, 7, -3, 2}));
    add_query(make_query('{1, -1, 3, 2, 5, -7, -4, 3, 9, 0, 1, 1}));
    add_query(make_query('{-3, 7, 1, 4, -2, 6, 1, 1, 1, 0, 3, 4}));

    for (int phase = 0; phase < 3; phase++) begin
      if (phase == 1) begin
        snd_idle = 71;
        rcv_idle = 15;
      end else if (phase == 2) begin
        snd_idle = 0;
        rcv_idle = 0;
      end
      repeat (430) add_query(random_query());
      while (pending_q.size() > 0 || in_if.valid) @(posedge clk_i);
    end
    while (expected_q.size() > 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("point_triangle_distance_sq_unit_test: clean");
    end else begin
      $display("point_triangle_distance_sq_unit_test: errors");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("point_triangle_distance_sq_unit_test: errors");
    $finish;
  end

endmodule
